// File: rtl/gdr_pkg.sv
package gdr_pkg;

    localparam int DIR_W     = 16;
    localparam int POS_W     = 22;
    localparam int SCR_W     = 12;
    localparam int RAY_W     = 18;
    localparam int CAMX_W    = 30;
    localparam int MUL_A_W   = 35;
    localparam int MUL_B_W   = 19;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DVS_W     = 22;
    localparam int DELTA_W   = 34;
    localparam int SQ_W      = 36;
    localparam int ROOT_W    = 32;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int DIST_W    = 22;
    localparam int LH_W      = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [LH_W-1:0]   LH_MAX   = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_POS_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_POS_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_Y     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_PLANE_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_PLANE_Y = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE, S_CAMX, S_MULX, S_RAYX, S_RAYY, S_SQA, S_SQB, S_SQRT, S_DX, S_DY,
        S_SIDEX, S_SIDEY, S_WINIT, S_STEP, S_CHECK, S_DIST, S_LH, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_MAP_WR, OP_START, OP_CAMX, OP_MULPX, OP_RAYX, OP_RAYY, OP_SQA,
        OP_SQB, OP_DXGO, OP_DXW, OP_DYW, OP_SIDEX, OP_SIDEY, OP_WINIT, OP_STEP,
        OP_FOUND, OP_MISS, OP_DIST, OP_LH, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic oob;
        logic wall;
        logic limit;
    } t_sts;

endpackage

// File: rtl/gdr_div.sv
module gdr_div #(
    parameter int DW = 40,
    parameter int VW = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   rem_sh;
    logic          ge;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? VW'(rem_sh - {1'b0, r_dvs}) : rem_sh[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: rtl/gdr_sqrt.sv
module gdr_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gdr_pkg::RAD_W-1:0]   i_radicand,
    output logic                        o_done,
    output logic [gdr_pkg::ROOT_W-1:0]  o_root
);

    localparam int RW = gdr_pkg::ROOT_W;
    localparam int CW = $clog2(RW + 1);

    logic [gdr_pkg::RAD_W-1:0] r_val;
    logic [RW+1:0]             r_rem;
    logic [RW-1:0]             r_root;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [RW+3:0]             rem_sh;
    logic [RW+3:0]             trial;
    logic                      ge;

    assign rem_sh = {r_rem, r_val[gdr_pkg::RAD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[gdr_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= ge ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
            r_root <= {r_root[RW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/gdr_ctrl.sv
module gdr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_action,
    input  logic          i_out_ready,
    input  gdr_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output gdr_pkg::t_cmd o_cmd
);

    gdr_pkg::t_state r_state;
    gdr_pkg::t_state n_state;
    logic            r_out_valid;
    logic            accept;
    logic            out_free;

    assign o_in_ready  = (r_state == gdr_pkg::S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gdr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == gdr_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = gdr_pkg::OP_NONE;
        unique case (r_state)
            gdr_pkg::S_IDLE: begin
                if (accept && i_action) begin
                    o_cmd.op = gdr_pkg::OP_START;
                    n_state  = gdr_pkg::S_CAMX;
                end else if (accept) begin
                    o_cmd.op = gdr_pkg::OP_MAP_WR;
                end
            end
            gdr_pkg::S_CAMX: begin
                if (i_sts.div_done) begin
                    o_cmd.op = gdr_pkg::OP_CAMX;
                    n_state  = gdr_pkg::S_MULX;
                end
            end
            gdr_pkg::S_MULX: begin
                o_cmd.op = gdr_pkg::OP_MULPX;
                n_state  = gdr_pkg::S_RAYX;
            end
            gdr_pkg::S_RAYX: begin
                o_cmd.op = gdr_pkg::OP_RAYX;
                n_state  = gdr_pkg::S_RAYY;
            end
            gdr_pkg::S_RAYY: begin
                o_cmd.op = gdr_pkg::OP_RAYY;
                n_state  = gdr_pkg::S_SQA;
            end
            gdr_pkg::S_SQA: begin
                o_cmd.op = gdr_pkg::OP_SQA;
                n_state  = gdr_pkg::S_SQB;
            end
            gdr_pkg::S_SQB: begin
                o_cmd.op = gdr_pkg::OP_SQB;
                n_state  = gdr_pkg::S_SQRT;
            end
            gdr_pkg::S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.op = gdr_pkg::OP_DXGO;
                    n_state  = gdr_pkg::S_DX;
                end
            end
            gdr_pkg::S_DX: begin
                if (i_sts.div_done) begin
                    o_cmd.op = gdr_pkg::OP_DXW;
                    n_state  = gdr_pkg::S_DY;
                end
            end
            gdr_pkg::S_DY: begin
                if (i_sts.div_done) begin
                    o_cmd.op = gdr_pkg::OP_DYW;
                    n_state  = gdr_pkg::S_SIDEX;
                end
            end
            gdr_pkg::S_SIDEX: begin
                o_cmd.op = gdr_pkg::OP_SIDEX;
                n_state  = gdr_pkg::S_SIDEY;
            end
            gdr_pkg::S_SIDEY: begin
                o_cmd.op = gdr_pkg::OP_SIDEY;
                n_state  = gdr_pkg::S_WINIT;
            end
            gdr_pkg::S_WINIT: begin
                o_cmd.op = gdr_pkg::OP_WINIT;
                n_state  = gdr_pkg::S_STEP;
            end
            gdr_pkg::S_STEP: begin
                o_cmd.op = gdr_pkg::OP_STEP;
                n_state  = gdr_pkg::S_CHECK;
            end
            gdr_pkg::S_CHECK: begin
                priority if (i_sts.oob) begin
                    o_cmd.op = gdr_pkg::OP_MISS;
                    n_state  = gdr_pkg::S_OUT;
                end else if (i_sts.wall) begin
                    o_cmd.op = gdr_pkg::OP_FOUND;
                    n_state  = gdr_pkg::S_DIST;
                end else if (i_sts.limit) begin
                    o_cmd.op = gdr_pkg::OP_MISS;
                    n_state  = gdr_pkg::S_OUT;
                end else begin
                    o_cmd.op = gdr_pkg::OP_STEP;
                end
            end
            gdr_pkg::S_DIST: begin
                if (i_sts.div_done) begin
                    o_cmd.op = gdr_pkg::OP_DIST;
                    n_state  = gdr_pkg::S_LH;
                end
            end
            gdr_pkg::S_LH: begin
                if (i_sts.div_done) begin
                    o_cmd.op = gdr_pkg::OP_LH;
                    n_state  = gdr_pkg::S_OUT;
                end
            end
            gdr_pkg::S_OUT: begin
                if (out_free) begin
                    o_cmd.op = gdr_pkg::OP_OUT;
                    n_state  = gdr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gdr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/gdr_dp.sv
module gdr_dp #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64,
    parameter int STEP_LIMIT = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gdr_pkg::t_cmd                   i_cmd,
    output gdr_pkg::t_sts                   o_sts,
    input  logic                            i_cfg_we,
    input  logic [gdr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gdr_pkg::POS_W-1:0]       i_cfg_data,
    input  logic [10:0]                     i_column,
    input  logic [5:0]                      i_cell_x,
    input  logic [5:0]                      i_cell_y,
    input  logic                            i_cell_is_wall,
    output logic [gdr_pkg::DIST_W-1:0]      o_wall_distance,
    output logic [gdr_pkg::LH_W-1:0]        o_line_height,
    output logic signed [15:0]              o_draw_start,
    output logic                            o_hit_side,
    output logic [5:0]                      o_hit_cell_x,
    output logic [5:0]                      o_hit_cell_y,
    output logic                            o_wall_found
);

    localparam int XW     = $clog2(MAP_WIDTH);
    localparam int YW     = $clog2(MAP_HEIGHT);
    localparam int MXW    = ((XW > 6) ? XW : 6) + 2;
    localparam int MYW    = ((YW > 6) ? YW : 6) + 2;
    localparam int C_W    = (MXW > MYW) ? MXW : MYW;
    localparam int NUM_W  = C_W + 18;
    localparam int DIV_W  = NUM_W + 14;
    localparam int ADDR_W = $clog2(MAP_WIDTH * MAP_HEIGHT);
    localparam int SIDE_W = 37 + $clog2(STEP_LIMIT);
    localparam int CNT_W  = $clog2(STEP_LIMIT + 1);
    localparam int RW     = gdr_pkg::RAY_W;

    // configuration
    logic [gdr_pkg::SCR_W-1:0]        r_sw;
    logic [gdr_pkg::SCR_W-1:0]        r_sh;
    logic [gdr_pkg::POS_W-1:0]        r_pos_x;
    logic [gdr_pkg::POS_W-1:0]        r_pos_y;
    logic signed [gdr_pkg::DIR_W-1:0] r_dir_x;
    logic signed [gdr_pkg::DIR_W-1:0] r_dir_y;
    logic signed [gdr_pkg::DIR_W-1:0] r_pln_x;
    logic signed [gdr_pkg::DIR_W-1:0] r_pln_y;

    // working registers
    logic signed [gdr_pkg::CAMX_W-1:0] r_camx;
    logic signed [gdr_pkg::PROD_W-1:0] r_prod;
    logic signed [RW-1:0]              r_rx;
    logic signed [RW-1:0]              r_ry;
    logic [gdr_pkg::SQ_W-1:0]          r_sq;
    logic [gdr_pkg::DELTA_W-1:0]       r_dx;
    logic [gdr_pkg::DELTA_W-1:0]       r_dy;
    logic [SIDE_W-1:0]                 r_sx;
    logic [SIDE_W-1:0]                 r_sy;
    logic signed [C_W-1:0]             r_mx;
    logic signed [C_W-1:0]             r_my;
    logic                              r_side;
    logic [CNT_W-1:0]                  r_steps;
    logic                              r_wall;
    logic                              r_found;
    logic                              r_dzero;
    logic                              r_dneg;
    logic [gdr_pkg::DIST_W-1:0]        r_dist;
    logic [gdr_pkg::LH_W-1:0]          r_lh;
    logic                              r_map [0:MAP_WIDTH*MAP_HEIGHT-1];

    logic [gdr_pkg::DIST_W-1:0] r_o_dist;
    logic [gdr_pkg::LH_W-1:0]   r_o_lh;
    logic [15:0]                r_o_ds;
    logic                       r_o_side;
    logic [5:0]                 r_o_hx;
    logic [5:0]                 r_o_hy;
    logic                       r_o_found;

    // step next values
    logic [SIDE_W-1:0]     n_sx;
    logic [SIDE_W-1:0]     n_sy;
    logic signed [C_W-1:0] n_mx;
    logic signed [C_W-1:0] n_my;
    logic                  n_side;
    logic [gdr_pkg::DIST_W-1:0] n_dist;

    logic signed [gdr_pkg::MUL_A_W-1:0] mul_a;
    logic signed [gdr_pkg::MUL_B_W-1:0] mul_b;
    logic signed [gdr_pkg::PROD_W-1:0]  mul_p;

    logic [RW-1:0]               mag_rx;
    logic [RW-1:0]               mag_ry;
    logic [16:0]                 fsel_x;
    logic [16:0]                 fsel_y;
    logic signed [39:0]          ray_full;
    logic signed [RW-1:0]        ray_sat;
    logic [gdr_pkg::SCR_W-1:0]   sw_eff;
    logic signed [C_W-1:0]       coord;
    logic [gdr_pkg::POS_W-1:0]   pos_sel;
    logic signed [RW-1:0]        rd;
    logic signed [NUM_W-1:0]     num;
    logic [NUM_W-1:0]            num_mag;
    logic [RW-1:0]               rd_mag;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        wr_ok;

    logic                        div_start;
    logic [DIV_W-1:0]            div_dvd;
    logic [gdr_pkg::DVS_W-1:0]   div_dvs;
    logic                        div_done;
    logic [DIV_W-1:0]            div_quot;
    logic                        sqrt_start;
    logic                        sqrt_done;
    logic [gdr_pkg::ROOT_W-1:0]  sqrt_root;
    logic [gdr_pkg::SQ_W-1:0]    sq_sum;

    function automatic logic signed [RW-1:0] sat_ray(input logic signed [39:0] v);
        logic signed [RW-1:0] res;
        if (v > 40'sd131071) begin
            res = {1'b0, {(RW-1){1'b1}}};
        end else if (v < -40'sd131072) begin
            res = {1'b1, {(RW-1){1'b0}}};
        end else begin
            res = v[RW-1:0];
        end
        return res;
    endfunction

    assign sw_eff = (r_sw == '0) ? gdr_pkg::SCR_W'(1) : r_sw;
    assign mag_rx = r_rx[RW-1] ? RW'(-r_rx) : r_rx;
    assign mag_ry = r_ry[RW-1] ? RW'(-r_ry) : r_ry;
    assign fsel_x = r_rx[RW-1] ? {1'b0, r_pos_x[15:0]} : 17'h10000 - {1'b0, r_pos_x[15:0]};
    assign fsel_y = r_ry[RW-1] ? {1'b0, r_pos_y[15:0]} : 17'h10000 - {1'b0, r_pos_y[15:0]};
    assign sq_sum = r_sq + gdr_pkg::SQ_W'(r_prod);

    // ray component from the product in flight
    always_comb begin
        if (i_cmd.op == gdr_pkg::OP_RAYX) begin
            ray_full = {{24{r_dir_x[15]}}, r_dir_x}
                     + {{2{r_prod[gdr_pkg::PROD_W-1]}}, r_prod[gdr_pkg::PROD_W-1:16]};
        end else begin
            ray_full = {{24{r_dir_y[15]}}, r_dir_y}
                     + {{2{r_prod[gdr_pkg::PROD_W-1]}}, r_prod[gdr_pkg::PROD_W-1:16]};
        end
        ray_sat = sat_ray(ray_full);
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            gdr_pkg::OP_MULPX: begin
                mul_a = gdr_pkg::MUL_A_W'(r_camx);
                mul_b = gdr_pkg::MUL_B_W'(r_pln_x);
            end
            gdr_pkg::OP_RAYX: begin
                mul_a = gdr_pkg::MUL_A_W'(r_camx);
                mul_b = gdr_pkg::MUL_B_W'(r_pln_y);
            end
            gdr_pkg::OP_RAYY: begin
                mul_a = signed'(gdr_pkg::MUL_A_W'(mag_rx));
                mul_b = signed'(gdr_pkg::MUL_B_W'(mag_rx));
            end
            gdr_pkg::OP_SQA: begin
                mul_a = signed'(gdr_pkg::MUL_A_W'(mag_ry));
                mul_b = signed'(gdr_pkg::MUL_B_W'(mag_ry));
            end
            gdr_pkg::OP_SIDEX: begin
                mul_a = signed'(gdr_pkg::MUL_A_W'(r_dx));
                mul_b = signed'(gdr_pkg::MUL_B_W'(fsel_x));
            end
            gdr_pkg::OP_SIDEY: begin
                mul_a = signed'(gdr_pkg::MUL_A_W'(r_dy));
                mul_b = signed'(gdr_pkg::MUL_B_W'(fsel_y));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // one dda step
    always_comb begin
        n_sx   = r_sx;
        n_sy   = r_sy;
        n_mx   = r_mx;
        n_my   = r_my;
        n_side = r_side;
        if (r_sx < r_sy) begin
            n_sx   = r_sx + SIDE_W'(r_dx);
            n_mx   = r_mx + (r_rx[RW-1] ? {C_W{1'b1}} : C_W'(1));
            n_side = 1'b0;
        end else begin
            n_sy   = r_sy + SIDE_W'(r_dy);
            n_my   = r_my + (r_ry[RW-1] ? {C_W{1'b1}} : C_W'(1));
            n_side = 1'b1;
        end
    end

    assign rd_addr = ADDR_W'(ADDR_W'(n_my) * ADDR_W'(MAP_WIDTH) + ADDR_W'(n_mx));
    assign wr_addr = ADDR_W'(ADDR_W'(i_cell_y) * ADDR_W'(MAP_WIDTH) + ADDR_W'(i_cell_x));
    assign wr_ok   = (32'(i_cell_x) < MAP_WIDTH) && (32'(i_cell_y) < MAP_HEIGHT);

    // perpendicular distance numerator
    always_comb begin
        coord   = r_side ? r_my : r_mx;
        pos_sel = r_side ? r_pos_y : r_pos_x;
        rd      = r_side ? r_ry : r_rx;
        num     = {{(NUM_W-C_W-16){coord[C_W-1]}}, coord, 16'h0000}
                - signed'(NUM_W'(pos_sel))
                + (rd[RW-1] ? signed'(NUM_W'(17'h10000)) : '0);
        num_mag = num[NUM_W-1] ? NUM_W'(-num) : num;
        rd_mag  = rd[RW-1] ? RW'(-rd) : rd;
    end

    always_comb begin
        if (r_dzero) begin
            n_dist = gdr_pkg::DIST_MAX;
        end else if (r_dneg) begin
            n_dist = '0;
        end else if (|div_quot[DIV_W-1:gdr_pkg::DIST_W]) begin
            n_dist = gdr_pkg::DIST_MAX;
        end else begin
            n_dist = div_quot[gdr_pkg::DIST_W-1:0];
        end
    end

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        unique case (i_cmd.op)
            gdr_pkg::OP_START: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'({i_column, 17'h00000});
                div_dvs   = gdr_pkg::DVS_W'(sw_eff);
            end
            gdr_pkg::OP_DXGO: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'({sqrt_root, 2'b00});
                div_dvs   = gdr_pkg::DVS_W'(mag_rx);
            end
            gdr_pkg::OP_DXW: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'({sqrt_root, 2'b00});
                div_dvs   = gdr_pkg::DVS_W'(mag_ry);
            end
            gdr_pkg::OP_FOUND: begin
                div_start = 1'b1;
                div_dvd   = {num_mag, 14'h0000};
                div_dvs   = gdr_pkg::DVS_W'(rd_mag);
            end
            gdr_pkg::OP_DIST: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'({r_sh, 16'h0000});
                div_dvs   = n_dist;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sqrt_start = (i_cmd.op == gdr_pkg::OP_SQB);

    gdr_div #(
        .DW (DIV_W),
        .VW (gdr_pkg::DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    gdr_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand ({sq_sum, 28'h0000000}),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw    <= 12'd640;
            r_sh    <= 12'd480;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_dir_x <= 16'sd16384;
            r_dir_y <= '0;
            r_pln_x <= '0;
            r_pln_y <= 16'sd10813;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gdr_pkg::CFG_SCREEN_WIDTH:   r_sw    <= i_cfg_data[gdr_pkg::SCR_W-1:0];
                gdr_pkg::CFG_SCREEN_HEIGHT:  r_sh    <= i_cfg_data[gdr_pkg::SCR_W-1:0];
                gdr_pkg::CFG_PLAYER_POS_X:   r_pos_x <= i_cfg_data;
                gdr_pkg::CFG_PLAYER_POS_Y:   r_pos_y <= i_cfg_data;
                gdr_pkg::CFG_VIEW_DIR_X:     r_dir_x <= i_cfg_data[gdr_pkg::DIR_W-1:0];
                gdr_pkg::CFG_VIEW_DIR_Y:     r_dir_y <= i_cfg_data[gdr_pkg::DIR_W-1:0];
                gdr_pkg::CFG_CAMERA_PLANE_X: r_pln_x <= i_cfg_data[gdr_pkg::DIR_W-1:0];
                gdr_pkg::CFG_CAMERA_PLANE_Y: r_pln_y <= i_cfg_data[gdr_pkg::DIR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // wall map
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == gdr_pkg::OP_MAP_WR && wr_ok) begin
            r_map[wr_addr] <= i_cell_is_wall;
        end
        if (i_cmd.op == gdr_pkg::OP_STEP) begin
            r_wall <= r_map[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (i_cmd.op)
            gdr_pkg::OP_CAMX: begin
                r_camx <= signed'({2'b00, div_quot[27:0]}) - 30'sd65536;
            end
            gdr_pkg::OP_RAYX: begin
                r_rx <= ray_sat;
            end
            gdr_pkg::OP_RAYY: begin
                r_ry <= ray_sat;
            end
            gdr_pkg::OP_SQA: begin
                r_sq <= gdr_pkg::SQ_W'(r_prod);
            end
            gdr_pkg::OP_DXW: begin
                if (r_ry == '0) begin
                    r_dx <= '0;
                end else if (r_rx == '0) begin
                    r_dx <= gdr_pkg::DELTA_W'(17'h10000);
                end else begin
                    r_dx <= div_quot[gdr_pkg::DELTA_W-1:0];
                end
            end
            gdr_pkg::OP_DYW: begin
                if (r_rx == '0) begin
                    r_dy <= '0;
                end else if (r_ry == '0) begin
                    r_dy <= gdr_pkg::DELTA_W'(17'h10000);
                end else begin
                    r_dy <= div_quot[gdr_pkg::DELTA_W-1:0];
                end
            end
            gdr_pkg::OP_SIDEY: begin
                r_sx <= SIDE_W'(r_prod[gdr_pkg::PROD_W-1:16]);
            end
            gdr_pkg::OP_WINIT: begin
                r_sy    <= SIDE_W'(r_prod[gdr_pkg::PROD_W-1:16]);
                r_mx    <= signed'(C_W'(r_pos_x[gdr_pkg::POS_W-1:16]));
                r_my    <= signed'(C_W'(r_pos_y[gdr_pkg::POS_W-1:16]));
                r_side  <= 1'b0;
                r_steps <= '0;
            end
            gdr_pkg::OP_STEP: begin
                r_sx    <= n_sx;
                r_sy    <= n_sy;
                r_mx    <= n_mx;
                r_my    <= n_my;
                r_side  <= n_side;
                r_steps <= r_steps + 1'b1;
            end
            gdr_pkg::OP_FOUND: begin
                r_found <= 1'b1;
                r_dzero <= (rd == '0);
                r_dneg  <= (num != '0) && (num[NUM_W-1] != rd[RW-1]);
            end
            gdr_pkg::OP_MISS: begin
                r_found <= 1'b0;
                r_dist  <= gdr_pkg::DIST_MAX;
                r_lh    <= '0;
            end
            gdr_pkg::OP_DIST: begin
                r_dist <= n_dist;
            end
            gdr_pkg::OP_LH: begin
                if (r_dist == '0 || (|div_quot[DIV_W-1:gdr_pkg::LH_W])) begin
                    r_lh <= gdr_pkg::LH_MAX;
                end else begin
                    r_lh <= div_quot[gdr_pkg::LH_W-1:0];
                end
            end
            gdr_pkg::OP_OUT: begin
                r_o_dist  <= r_dist;
                r_o_lh    <= r_lh;
                r_o_ds    <= {5'b00000, r_sh[gdr_pkg::SCR_W-1:1]} - {1'b0, r_lh[gdr_pkg::LH_W-1:1]};
                r_o_side  <= r_found & r_side;
                r_o_hx    <= r_found ? r_mx[5:0] : 6'd0;
                r_o_hy    <= r_found ? r_my[5:0] : 6'd0;
                r_o_found <= r_found;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.div_done  = div_done;
    assign o_sts.sqrt_done = sqrt_done;
    assign o_sts.oob       = r_mx[C_W-1] || (r_mx >= signed'(C_W'(MAP_WIDTH)))
                          || r_my[C_W-1] || (r_my >= signed'(C_W'(MAP_HEIGHT)));
    assign o_sts.wall      = r_wall;
    assign o_sts.limit     = (r_steps == CNT_W'(STEP_LIMIT));

    assign o_wall_distance = r_o_dist;
    assign o_line_height   = r_o_lh;
    assign o_draw_start    = signed'(r_o_ds);
    assign o_hit_side      = r_o_side;
    assign o_hit_cell_x    = r_o_hx;
    assign o_hit_cell_y    = r_o_hy;
    assign o_wall_found    = r_o_found;

endmodule

// File: rtl/grid_dda_ray_caster.sv
// map write: no result; the block stays idle and ready for the next item
// cast: walks at most STEP_LIMIT cells, one per cycle; a ray that misses skips the last two
// divides; the divider is shared and yields one quotient bit per cycle (five divides on a hit)
// and the root unit works in 32 steps
// a cast is taken only with the block idle; a finished result waits in the output register
// reset is synchronous active low: control and config registers return to defaults,
// the wall map is not cleared by reset
module grid_dda_ray_caster #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64,
    parameter int STEP_LIMIT = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gdr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gdr_pkg::POS_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [10:0]                   i_column,
    input  logic [5:0]                    i_cell_x,
    input  logic [5:0]                    i_cell_y,
    input  logic                          i_cell_is_wall,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [21:0]                   o_wall_distance,
    output logic [15:0]                   o_line_height,
    output logic signed [15:0]            o_draw_start,
    output logic                          o_hit_side,
    output logic [5:0]                    o_hit_cell_x,
    output logic [5:0]                    o_hit_cell_y,
    output logic                          o_wall_found
);

    gdr_pkg::t_cmd cmd;
    gdr_pkg::t_sts sts;

    gdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    gdr_dp #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .STEP_LIMIT (STEP_LIMIT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_column        (i_column),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_is_wall  (i_cell_is_wall),
        .o_wall_distance (o_wall_distance),
        .o_line_height   (o_line_height),
        .o_draw_start    (o_draw_start),
        .o_hit_side      (o_hit_side),
        .o_hit_cell_x    (o_hit_cell_x),
        .o_hit_cell_y    (o_hit_cell_y),
        .o_wall_found    (o_wall_found)
    );

    // a cast transfer makes the block busy
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action) |=> !o_in_ready)
        else $error("block still ready after a cast transfer");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_wall_found) |->
        (o_line_height == 16'd0 && o_wall_distance == gdr_pkg::DIST_MAX
         && o_hit_cell_x == 6'd0 && o_hit_cell_y == 6'd0 && !o_hit_side))
        else $error("missed ray with nonzero hit fields");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_wall_found && o_wall_distance == 22'd0) |->
        (o_line_height == gdr_pkg::LH_MAX))
        else $error("zero distance without saturated line height");

endmodule
